// ===== hw/rtl/nmea_ck_pkg.sv =====
// Package for the NMEA line checksum checker.
// Holds the parse phase type, verdict codes, character constants and a hex decode function.
// It has no dependencies.
package nmea_ck_pkg;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_BODY   = 3'd2,
        PH_HEX    = 3'd3,
        PH_AFTER  = 3'd4,
        PH_REJECT = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        VERDICT_VALID    = 2'd0,
        VERDICT_NO_START = 2'd1,
        VERDICT_NO_SUM   = 2'd2,
        VERDICT_MISMATCH = 2'd3
    } t_verdict;

    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] LINE_LIMIT_RESET = 8'd90;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] value;
    } t_hex_digit;

    function automatic t_hex_digit hex_decode(input logic [7:0] c);
        t_hex_digit d;
        d.is_digit = 1'b0;
        d.value    = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.is_digit = 1'b1;
            d.value    = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.is_digit = 1'b1;
            d.value    = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.is_digit = 1'b1;
            d.value    = 4'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

// ===== hw/rtl/nmea_line_checksum_checker.sv =====
// Top level of the NMEA line checksum checker: frames bytes into lines and checks each sentence.
// A verdict is registered into the result register on the newline transfer.
// Throughput: one byte per cycle; the output register lets a byte be taken while a
// result waits, and the input stalls only when a held result is not taken.
// Reset (synchronous, active low) clears the line state, sets the limit to 90 and drops any result.
// Depends on nmea_ck_pkg.
module nmea_line_checksum_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [7:0]              i_cfg_line_limit,
    input  logic                    i_rx_valid,
    output logic                    o_rx_ready,
    input  logic [7:0]              i_rx_byte,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output nmea_ck_pkg::t_verdict   o_verdict,
    output logic [7:0]              o_computed_sum,
    output logic [7:0]              o_reported_sum,
    output logic [7:0]              o_line_length
);
    import nmea_ck_pkg::*;

    logic [7:0] r_limit;
    logic [7:0] r_pos,  n_pos;
    t_phase     r_phase, n_phase;
    logic [7:0] r_xor,  n_xor;
    logic [7:0] r_hex,  n_hex;
    logic       r_big,  n_big;
    logic       r_seen, n_seen;

    logic       r_res_valid;
    t_verdict   r_verdict, n_verdict;
    logic [7:0] r_comp, n_comp;
    logic [7:0] r_rep,  n_rep;
    logic [7:0] r_len;

    logic       rx_fire;
    logic [8:0] next_count;
    logic       overlong;
    logic       line_end;
    t_hex_digit digit;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = !r_res_valid || i_res_ready;
    assign rx_fire     = i_rx_valid && o_rx_ready;
    assign next_count  = {1'b0, r_pos} + 9'd1;
    assign overlong    = next_count > {1'b0, r_limit};
    assign line_end    = !overlong && (i_rx_byte == CHAR_NEWLINE);
    assign digit       = hex_decode(i_rx_byte);

    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_xor     = r_xor;
        n_hex     = r_hex;
        n_big     = r_big;
        n_seen    = r_seen;
        n_verdict = VERDICT_NO_SUM;
        n_comp    = r_xor;
        n_rep     = 8'd0;
        case (r_phase)
            PH_FIRST, PH_REJECT: begin
                n_verdict = VERDICT_NO_START;
                n_comp    = 8'd0;
            end
            PH_HEX, PH_AFTER: begin
                if (r_seen) begin
                    n_rep     = r_hex;
                    n_verdict = (!r_big && r_hex == r_xor) ? VERDICT_VALID
                                                           : VERDICT_MISMATCH;
                end
            end
            default: begin
                n_verdict = VERDICT_NO_SUM;
            end
        endcase
        if (overlong || line_end) begin
            n_pos   = 8'd0;
            n_phase = PH_FIRST;
            n_xor   = 8'd0;
            n_hex   = 8'd0;
            n_big   = 1'b0;
            n_seen  = 1'b0;
        end else begin
            n_pos = next_count[7:0];
            case (r_phase)
                PH_FIRST: begin
                    n_phase = (i_rx_byte == CHAR_DOLLAR) ? PH_SECOND : PH_REJECT;
                end
                PH_SECOND, PH_BODY: begin
                    if (r_phase == PH_SECOND && i_rx_byte == CHAR_DOLLAR) begin
                        n_phase = PH_REJECT;
                    end else if (i_rx_byte == CHAR_STAR) begin
                        n_phase = PH_HEX;
                    end else begin
                        n_xor   = r_xor ^ i_rx_byte;
                        n_phase = PH_BODY;
                    end
                end
                PH_HEX: begin
                    if (!digit.is_digit) begin
                        n_phase = PH_AFTER;
                    end else begin
                        if (r_hex[7:4] != 4'd0) begin
                            n_big = 1'b1;
                        end
                        n_hex  = {r_hex[3:0], digit.value};
                        n_seen = 1'b1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LINE_LIMIT_RESET;
            r_pos       <= 8'd0;
            r_phase     <= PH_FIRST;
            r_xor       <= 8'd0;
            r_hex       <= 8'd0;
            r_big       <= 1'b0;
            r_seen      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_line_limit;
            end
            if (rx_fire) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_xor   <= n_xor;
                r_hex   <= n_hex;
                r_big   <= n_big;
                r_seen  <= n_seen;
            end
            if (rx_fire && line_end) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_fire && line_end) begin
            r_verdict <= n_verdict;
            r_comp    <= n_comp;
            r_rep     <= n_rep;
            r_len     <= next_count[7:0];
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_verdict      = r_verdict;
    assign o_computed_sum = r_comp;
    assign o_reported_sum = r_rep;
    assign o_line_length  = r_len;

    a_newline_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_fire && line_end |=> o_res_valid && r_pos == 8'd0 && r_phase == PH_FIRST)
        else $error("newline transfer did not produce a result and clear the line");

    a_overlong_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_fire && overlong |=> r_pos == 8'd0 && !r_seen && r_xor == 8'd0)
        else $error("overlong line did not clear the line state");

    a_no_start_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_verdict == VERDICT_NO_START |-> o_computed_sum == 8'd0
            && o_reported_sum == 8'd0)
        else $error("rejected start carries a nonzero sum");

    a_no_field_zero_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_verdict == VERDICT_NO_SUM |-> o_reported_sum == 8'd0)
        else $error("missing checksum field carries a reported sum");

    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_line_length != 8'd0)
        else $error("result with zero line length");

endmodule
